// ----- rtl/core/m3ro_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3ro_pkg
// Shared constants and types of the 3D mesh relative offset block.
// ----------------------------------------------------------------------------
package m3ro_pkg;

   // width of a node number on the request channel
   localparam int NodeBits      = 16;
   // width of one mesh size register and of one offset
   localparam int CfgBits       = 7;
   localparam int OffsetBits    = 7;
   // restoring divide steps done between two pipeline registers
   localparam int StepsPerStage = 4;
   // stages of one divide; two divides (row width, then column height)
   localparam int DivStages     = NodeBits / StepsPerStage;
   localparam int PipeStages    = 2 * DivStages;
   // largest offset that is reported
   localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};

   // register index of the configuration port
   localparam int CsrIndexBits = 1;
   typedef enum logic [CsrIndexBits-1:0] {
      CSR_ROW_WIDTH     = 1'b0,
      CSR_COLUMN_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CfgBits-1:0] RowWidthReset     = CfgBits'(4);
   localparam logic [CfgBits-1:0] ColumnHeightReset = CfgBits'(4);

   // one node number on its way through the divider
   typedef struct packed {
      logic [NodeBits-1:0] work;   // dividend bits on top, quotient bits below
      logic [CfgBits-1:0]  rem;    // partial remainder
      logic [CfgBits-1:0]  x;      // X coordinate, kept after the first divide
   } lane_type;

   typedef struct packed {
      lane_type src;
      lane_type dst;
   } stage_type;

   typedef struct packed {
      logic                  backward;
      logic [OffsetBits-1:0] offset;
   } dim_type;

endpackage

// ----- rtl/core/m3ro_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3ro_req_if
// Request channel: source and destination node numbers.
// ----------------------------------------------------------------------------
interface m3ro_req_if;
   logic                          valid;
   logic                          ready;
   logic [m3ro_pkg::NodeBits-1:0] source_node;
   logic [m3ro_pkg::NodeBits-1:0] destination_node;

   modport source (output valid, output source_node, output destination_node, input ready);
   modport sink   (input valid, input source_node, input destination_node, output ready);
endinterface

// ----------------------------------------------------------------------------
// m3ro_rsp_if
// Result channel: direction bit and offset of each mesh dimension.
// ----------------------------------------------------------------------------
interface m3ro_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            x_backward;
   logic [m3ro_pkg::OffsetBits-1:0] x_offset;
   logic                            y_backward;
   logic [m3ro_pkg::OffsetBits-1:0] y_offset;
   logic                            z_backward;
   logic [m3ro_pkg::OffsetBits-1:0] z_offset;

   modport source (output valid, output x_backward, output x_offset, output y_backward,
                   output y_offset, output z_backward, output z_offset, input ready);
   modport sink   (input valid, input x_backward, input x_offset, input y_backward,
                   input y_offset, input z_backward, input z_offset, output ready);
endinterface

// ----- rtl/core/mesh3d_relative_offset.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh3d_relative_offset
// Relative route offset between two nodes of a 3D mesh.
// ----------------------------------------------------------------------------
// Takes one item (source and destination node) per clock unless a stall backs
// up from the result side, and returns one item with a direction bit and a
// saturated offset for X, Y and Z. The block takes a new item every cycle while
// the first stage is not held by such a stall. An accepted item loads the first
// of eight divider stages and moves through them to the output register. Both node
// numbers go through a restoring divider that is unrolled into eight stages
// of four steps each, first dividing by the row width (remainder X) and then
// dividing that quotient by the column height (remainder Y, quotient Z),
// followed by the compare and output register.
// A size register that holds zero acts as one. Write the size registers only
// while no item is in flight.
// ----------------------------------------------------------------------------
module mesh3d_relative_offset (
   input  logic                                clock,
   input  logic                                reset,
   m3ro_req_if.sink                            req_channel,
   m3ro_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [m3ro_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [m3ro_pkg::CfgBits-1:0]        csr_write_data
);

   localparam int Stages = m3ro_pkg::PipeStages;
   localparam int NB     = m3ro_pkg::NodeBits;
   localparam int CB     = m3ro_pkg::CfgBits;

   logic [CB-1:0] row_width_ff;
   logic [CB-1:0] column_height_ff;
   logic [CB-1:0] div_w;
   logic [CB-1:0] div_h;

   m3ro_pkg::stage_type stage_ff [Stages];
   m3ro_pkg::stage_type stage_in [Stages];
   logic [Stages-1:0]   valid_ff;
   logic [Stages-1:0]   ready;

   logic            rsp_valid_ff;
   logic            rsp_ready;
   m3ro_pkg::dim_type x_ff, y_ff, z_ff;
   m3ro_pkg::dim_type x_in, y_in, z_in;

   // ------------------------------------------------------------------------
   // four restoring divide steps on one lane
   function automatic m3ro_pkg::lane_type div_block(m3ro_pkg::lane_type l,
                                                   logic [CB-1:0] d);
      logic [CB:0]        t;
      m3ro_pkg::lane_type r;
      r = l;
      for (int i = 0; i < m3ro_pkg::StepsPerStage; i++) begin
         t      = {r.rem, r.work[NB-1]};
         r.work = {r.work[NB-2:0], 1'b0};
         if (t >= {1'b0, d}) begin
            r.rem     = CB'(t - {1'b0, d});
            r.work[0] = 1'b1;
         end else begin
            r.rem = t[CB-1:0];
         end
      end
      return r;
   endfunction

   // direction and saturated distance of one coordinate pair
   function automatic m3ro_pkg::dim_type dim_compare(logic [NB-1:0] s, logic [NB-1:0] t);
      logic [NB-1:0]     d;
      m3ro_pkg::dim_type r;
      r.backward = (t < s);
      d          = r.backward ? (s - t) : (t - s);
      r.offset   = (d > NB'(m3ro_pkg::OffsetMax)) ? m3ro_pkg::OffsetMax
                                                   : d[m3ro_pkg::OffsetBits-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= m3ro_pkg::RowWidthReset;
         column_height_ff <= m3ro_pkg::ColumnHeightReset;
      end else if (csr_write_enable) begin
         case (m3ro_pkg::csr_index_type'(csr_index))
            m3ro_pkg::CSR_ROW_WIDTH:     row_width_ff     <= csr_write_data;
            m3ro_pkg::CSR_COLUMN_HEIGHT: column_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // treat a zero size as one
   assign div_w = (row_width_ff == '0)     ? CB'(1) : row_width_ff;
   assign div_h = (column_height_ff == '0) ? CB'(1) : column_height_ff;

   // ------------------------------------------------------------------------
   // ready chain: a stage advances when empty or when the next one advances
   assign rsp_ready = !rsp_valid_ff || rsp_channel.ready;

   always_comb begin
      ready[Stages-1] = !valid_ff[Stages-1] || rsp_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_channel.ready = ready[0];

   // ------------------------------------------------------------------------
   // divider stages: row width first, then column height on the quotient
   always_comb begin
      m3ro_pkg::stage_type prev;
      logic [CB-1:0]       d;
      for (int k = 0; k < Stages; k++) begin
         if (k == 0) begin
            prev.src.work = req_channel.source_node;
            prev.src.rem  = '0;
            prev.src.x    = '0;
            prev.dst.work = req_channel.destination_node;
            prev.dst.rem  = '0;
            prev.dst.x    = '0;
         end else begin
            prev = stage_ff[k-1];
         end
         // hand over: remainder is X, quotient becomes the new dividend
         if (k == m3ro_pkg::DivStages) begin
            prev.src.x   = prev.src.rem;
            prev.src.rem = '0;
            prev.dst.x   = prev.dst.rem;
            prev.dst.rem = '0;
         end
         d = (k < m3ro_pkg::DivStages) ? div_w : div_h;
         stage_in[k].src = div_block(prev.src, d);
         stage_in[k].dst = div_block(prev.dst, d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_channel.valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Stages; k++) begin
         if (ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // compare coordinates of the last stage
   always_comb begin
      m3ro_pkg::stage_type last;
      last = stage_ff[Stages-1];
      x_in = dim_compare(NB'(last.src.x),   NB'(last.dst.x));
      y_in = dim_compare(NB'(last.src.rem), NB'(last.dst.rem));
      z_in = dim_compare(last.src.work,     last.dst.work);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= valid_ff[Stages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.x_backward = x_ff.backward;
   assign rsp_channel.x_offset   = x_ff.offset;
   assign rsp_channel.y_backward = y_ff.backward;
   assign rsp_channel.y_offset   = y_ff.offset;
   assign rsp_channel.z_backward = z_ff.backward;
   assign rsp_channel.z_offset   = z_ff.offset;

   // ------------------------------------------------------------------------
   // assertions
   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_channel.valid && req_channel.ready |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !ready[0] |=> valid_ff[0] && $stable(stage_ff[0]))
      else $error("stalled stage lost or changed its item");

   a_x_below_width: assert property (@(posedge clock) disable iff (reset)
      valid_ff[m3ro_pkg::DivStages-1] |->
         stage_ff[m3ro_pkg::DivStages-1].src.rem < div_w &&
         stage_ff[m3ro_pkg::DivStages-1].dst.rem < div_w)
      else $error("X remainder not below row width");

   a_zero_offset_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.x_offset == '0 |-> !rsp_channel.x_backward)
      else $error("zero X offset flagged backward");

endmodule

// ----- dv/m3ro_offset_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3ro_offset_checker
// Watches the request, result and register ports of the 3D mesh offset block.
// Each accepted request is turned into the expected direction bits and
// offsets, using its own copy of the mesh size registers. Each accepted
// result is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module m3ro_offset_checker (
   input  logic                              clock,
   input  logic                              reset,
   m3ro_req_if                               req_mon,
   m3ro_rsp_if                               rsp_mon,
   input  logic                              csr_write_enable,
   input  logic [m3ro_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [m3ro_pkg::CfgBits-1:0]      csr_write_data,
   output int                                mismatch_count,
   output int                                outstanding_count
);

   typedef struct packed {
      m3ro_pkg::dim_type x;
      m3ro_pkg::dim_type y;
      m3ro_pkg::dim_type z;
   } route_offset_type;

   // shadow copy of the mesh size registers
   logic [m3ro_pkg::CfgBits-1:0] row_width_q;
   logic [m3ro_pkg::CfgBits-1:0] column_height_q;

   // offsets still owed by the block, oldest first
   route_offset_type route_queue[$];

   // direction and saturated distance along one axis
   function automatic m3ro_pkg::dim_type axis_offset(input int unsigned src_coord,
                                                     input int unsigned dst_coord);
      m3ro_pkg::dim_type result;
      int unsigned       distance;
      result.backward = (dst_coord < src_coord);
      distance = result.backward ? src_coord - dst_coord : dst_coord - src_coord;
      result.offset = (distance > m3ro_pkg::OffsetMax) ? m3ro_pkg::OffsetMax
                                                       : m3ro_pkg::OffsetBits'(distance);
      return result;
   endfunction

   // split both node numbers into mesh coordinates and compare them
   function automatic route_offset_type predict_route(
         input logic [m3ro_pkg::NodeBits-1:0] src,
         input logic [m3ro_pkg::NodeBits-1:0] dst);
      int unsigned      w;
      int unsigned      h;
      int unsigned      layer;
      int unsigned      s;
      int unsigned      d;
      route_offset_type result;
      // a size register that holds zero acts as one
      w = (row_width_q == '0) ? 1 : row_width_q;
      h = (column_height_q == '0) ? 1 : column_height_q;
      layer = w * h;
      s = src;
      d = dst;
      result.x = axis_offset(s % w, d % w);
      result.y = axis_offset((s % layer) / w, (d % layer) / w);
      result.z = axis_offset(s / layer, d / layer);
      return result;
   endfunction

   task automatic check_field(input string field,
                              input logic [m3ro_pkg::OffsetBits-1:0] expected_value,
                              input logic [m3ro_pkg::OffsetBits-1:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: %s mismatch: expected %0d actual %0d",
                  $time, field, expected_value, actual_value);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      route_offset_type expected_route;
      if (reset) begin
         row_width_q     <= m3ro_pkg::RowWidthReset;
         column_height_q <= m3ro_pkg::ColumnHeightReset;
         route_queue.delete();
      end else begin
         // retire one result against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (route_queue.size() == 0) begin
               $display("%0t: unexpected result item: x %0d/%0d y %0d/%0d z %0d/%0d",
                        $time, rsp_mon.x_backward, rsp_mon.x_offset,
                        rsp_mon.y_backward, rsp_mon.y_offset,
                        rsp_mon.z_backward, rsp_mon.z_offset);
               mismatch_count++;
            end else begin
               expected_route = route_queue.pop_front();
               check_field("x_backward",
                           m3ro_pkg::OffsetBits'(expected_route.x.backward),
                           m3ro_pkg::OffsetBits'(rsp_mon.x_backward));
               check_field("x_offset", expected_route.x.offset, rsp_mon.x_offset);
               check_field("y_backward",
                           m3ro_pkg::OffsetBits'(expected_route.y.backward),
                           m3ro_pkg::OffsetBits'(rsp_mon.y_backward));
               check_field("y_offset", expected_route.y.offset, rsp_mon.y_offset);
               check_field("z_backward",
                           m3ro_pkg::OffsetBits'(expected_route.z.backward),
                           m3ro_pkg::OffsetBits'(rsp_mon.z_backward));
               check_field("z_offset", expected_route.z.offset, rsp_mon.z_offset);
            end
         end

         // predict each accepted request item
         if (req_mon.valid && req_mon.ready) begin
            route_queue.insert(route_queue.size(),
                               predict_route(req_mon.source_node,
                                             req_mon.destination_node));
         end

         // follow register writes
         if (csr_write_enable) begin
            case (m3ro_pkg::csr_index_type'(csr_index))
               m3ro_pkg::CSR_ROW_WIDTH:     row_width_q     <= csr_write_data;
               m3ro_pkg::CSR_COLUMN_HEIGHT: column_height_q <= csr_write_data;
               default: ;
            endcase
         end
      end
      outstanding_count = route_queue.size();
   end

endmodule

// ----- dv/tb_mesh3d_relative_offset.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh3d_relative_offset
// Stimulus and verdict for the 3D mesh relative offset block.
// Sends a directed set of node pairs at the reset mesh size, then random
// pairs over a series of mesh sizes (extremes and zero sizes among them),
// with random gaps on the request side and random stalls on the result side.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_mesh3d_relative_offset;

   localparam int CycleLimit   = 200000;
   localparam int DrainCycles  = 16;
   localparam int SizePlanLen  = 12;
   localparam int ItemsPerSize = 96;
   localparam int DirectedLen  = 18;
   localparam int NB           = m3ro_pkg::NodeBits;
   localparam int CB           = m3ro_pkg::CfgBits;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [m3ro_pkg::CsrIndexBits-1:0] csr_index;
   logic [CB-1:0]                     csr_write_data;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int outstanding_count;
   int cycle_count;

   // mesh size last written, used to shape the random node numbers
   logic [CB-1:0] mesh_row;
   logic [CB-1:0] mesh_column;

   logic [CB-1:0] row_plan    [SizePlanLen];
   logic [CB-1:0] column_plan [SizePlanLen];
   logic [NB-1:0] directed_src[DirectedLen];
   logic [NB-1:0] directed_dst[DirectedLen];

   m3ro_req_if req_channel ();
   m3ro_rsp_if rsp_channel ();

   mesh3d_relative_offset dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_channel),
      .rsp_channel      (rsp_channel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   m3ro_offset_checker offset_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_channel),
      .rsp_mon           (rsp_channel),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stall the result side at random
   initial begin
      rsp_channel.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_channel.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // write both mesh size registers
   task automatic write_mesh_size(input logic [CB-1:0] row,
                                  input logic [CB-1:0] column);
      csr_write_enable <= 1'b1;
      csr_index        <= m3ro_pkg::CSR_ROW_WIDTH;
      csr_write_data   <= row;
      @(posedge clock);
      csr_index        <= m3ro_pkg::CSR_COLUMN_HEIGHT;
      csr_write_data   <= column;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mesh_row    = row;
      mesh_column = column;
   endtask

   // offer one item after a random gap and hold it until accepted
   task automatic send_route(input logic [NB-1:0] src,
                             input logic [NB-1:0] dst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_channel.valid <= 1'b0;
         @(posedge clock);
      end
      req_channel.valid            <= 1'b1;
      req_channel.source_node      <= src;
      req_channel.destination_node <= dst;
      @(posedge clock);
      while (!req_channel.ready) @(posedge clock);
   endtask

   // drop valid and wait until every expected item has come back
   task automatic drain_results();
      req_channel.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      int unsigned   eff_row;
      int unsigned   eff_column;
      int unsigned   layer;
      int unsigned   span;
      int unsigned   node_limit;
      int            delta;
      logic [NB-1:0] src;
      logic [NB-1:0] dst;

      reset                        = 1'b1;
      req_channel.valid            = 1'b0;
      req_channel.source_node      = '0;
      req_channel.destination_node = '0;
      csr_write_enable             = 1'b0;
      csr_index                    = m3ro_pkg::CSR_ROW_WIDTH;
      csr_write_data               = '0;
      cycle_count                  = 0;
      send_idle_pct                = 21;
      recv_idle_pct                = 52;
      mesh_row                     = m3ro_pkg::RowWidthReset;
      mesh_column                  = m3ro_pkg::ColumnHeightReset;

      // mesh sizes: extremes, zero sizes, odd shapes and random ones
      row_plan    = '{1, 127, 0, 0, 127, 1, 127, 3, 0, 0, 16, 0};
      column_plan = '{1, 127, 0, 127, 0, 127, 1, 5, 0, 0, 16, 0};
      row_plan[8]     = CB'($urandom_range(127));
      column_plan[8]  = CB'($urandom_range(127));
      row_plan[9]     = CB'($urandom_range(127));
      column_plan[9]  = CB'($urandom_range(127));
      row_plan[11]    = CB'($urandom_range(127));
      column_plan[11] = CB'($urandom_range(127));

      // directed pairs at the 4 x 4 reset mesh (layer of 16 nodes):
      // field extremes, equal coordinates, each axis both ways, Z saturation
      directed_src = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd5, 16'd3,
                       16'd0,    16'd12,   16'd0,    16'd16,   16'd0, 16'd0,
                       16'd2048, 16'h5555, 16'hAAAA, 16'h8000, 16'd1, 16'd6};
      directed_dst = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd5, 16'd0,
                       16'd3,    16'd0,    16'd12,   16'd0,    16'd2032, 16'd2048,
                       16'd0,    16'hAAAA, 16'h5555, 16'h7FFF, 16'd2, 16'd9};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_src[i]) send_route(directed_src[i], directed_dst[i]);
      drain_results();

      for (int seg = 0; seg < SizePlanLen; seg++) begin
         // sender light and receiver heavy, then swapped, then no idling
         if (seg == SizePlanLen / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 21;
         end else if (seg == 2 * SizePlanLen / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_mesh_size(row_plan[seg], column_plan[seg]);

         eff_row    = (mesh_row == '0) ? 1 : mesh_row;
         eff_column = (mesh_column == '0) ? 1 : mesh_column;
         layer      = eff_row * eff_column;
         span       = layer * 4;
         node_limit = (layer * 8 > 65536) ? 65535 : layer * 8 - 1;

         for (int k = 0; k < ItemsPerSize; k++) begin
            src = NB'($urandom_range(65535));
            case ($urandom_range(3))
               // destination within four layers of the source: small Z offset
               2: begin
                  delta = int'($urandom_range(2 * span)) - int'(span);
                  dst = src + NB'(delta);
               end
               // both nodes in the first eight layers
               3: begin
                  src = NB'($urandom_range(node_limit));
                  dst = NB'($urandom_range(node_limit));
               end
               default: dst = NB'($urandom_range(65535));
            endcase
            send_route(src, dst);
         end
         drain_results();
      end

      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- mesh3d_relative_offset.f -----
rtl/core/m3ro_pkg.sv
rtl/core/m3ro_req_if.sv
rtl/core/mesh3d_relative_offset.sv
dv/m3ro_offset_checker.sv
dv/tb_mesh3d_relative_offset.sv
